// ===== rtl/rcsc_pkg.sv =====
//------------------------------------------------------------------------------
// rcsc_pkg
// Shared types and constants for the RC stick conditioner.
//------------------------------------------------------------------------------
package rcsc_pkg;

  localparam int PULSE_W = 15;
  localparam int CMD_W   = 16;
  localparam logic [PULSE_W-1:0] CENTER_PULSE = 15'd1500;

  // register indexes
  typedef enum logic [2:0] {
    REG_PULSE_MIN  = 3'd0,
    REG_PULSE_MAX  = 3'd1,
    REG_ARM_MARGIN = 3'd2,
    REG_ROLL_LIM   = 3'd3,
    REG_PITCH_LIM  = 3'd4,
    REG_YAW_LIM    = 3'd5,
    REG_THR_LIM    = 3'd6,
    REG_TILT_LIM   = 3'd7
  } reg_idx_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic [PULSE_W-1:0] thr;
    logic [PULSE_W-1:0] rol;
    logic [PULSE_W-1:0] pit;
    logic [PULSE_W-1:0] yaw;
    logic               armed;
    logic               failsafe;
  } frame_t;

  typedef struct packed {
    logic                    armed;
    logic                    failsafe;
    logic signed [CMD_W-1:0] roll;
    logic signed [CMD_W-1:0] pitch;
    logic signed [CMD_W-1:0] yaw;
    logic [PULSE_W-1:0]      thr;
  } result_t;

endpackage

// ===== rtl/rc_stick_conditioner_with_arming.sv =====
//------------------------------------------------------------------------------
// rc_stick_conditioner_with_arming
// Radio frame conditioner with arming gestures and APB configuration.
//------------------------------------------------------------------------------
// From the pop of the internal queue to the result, each of the four axes takes a
// multiply, a 34-step shared restoring divider, then scaling, clamp and deadband;
// then come the tilt check and the result. Tilt limiting adds a square root and two
// more divider passes. With pulse_max equal to pulse_min an axis skips the multiply
// and the divider. A frame is registered in the queue before the pop, and the back
// starts the next frame only once the previous result has been popped. The front
// classifies and queues up to two frames while the back works.
module rc_stick_conditioner_with_arming #(
  parameter int ROLL_DEADBAND     = 16,
  parameter int PITCH_DEADBAND    = 16,
  parameter int YAW_DEADBAND      = 16,
  parameter int THROTTLE_DEADBAND = 16,
  parameter int YAW_TRIM          = 192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [14:0]        throttle_pulse,
  input  logic [14:0]        roll_pulse,
  input  logic [14:0]        pitch_pulse,
  input  logic [14:0]        yaw_pulse,
  output logic               empty,
  input  logic               pop,
  output logic               armed,
  output logic               failsafe,
  output logic signed [15:0] roll_cmd,
  output logic signed [15:0] pitch_cmd,
  output logic signed [15:0] yaw_cmd,
  output logic [14:0]        throttle_cmd
);

  logic [14:0] pulse_min, pulse_max, roll_limit, pitch_limit, yaw_limit;
  logic [14:0] throttle_limit, tilt_limit;
  logic [9:0]  arm_margin;
  logic q_full, q_push, q_empty, q_pop, res_valid;
  rcsc_pkg::frame_t q_in, q_out;
  rcsc_pkg::result_t res;
  rcsc_pkg::reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx = rcsc_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min <= 15'd1000; pulse_max <= 15'd2000; arm_margin <= 10'd50;
      roll_limit <= 15'd480; pitch_limit <= 15'd480; yaw_limit <= 15'd2880;
      throttle_limit <= 15'd16000; tilt_limit <= 15'd480;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        rcsc_pkg::REG_PULSE_MIN:  pulse_min <= pwdata[14:0];
        rcsc_pkg::REG_PULSE_MAX:  pulse_max <= pwdata[14:0];
        rcsc_pkg::REG_ARM_MARGIN: arm_margin <= pwdata[9:0];
        rcsc_pkg::REG_ROLL_LIM:   roll_limit <= pwdata[14:0];
        rcsc_pkg::REG_PITCH_LIM:  pitch_limit <= pwdata[14:0];
        rcsc_pkg::REG_YAW_LIM:    yaw_limit <= pwdata[14:0];
        rcsc_pkg::REG_THR_LIM:    throttle_limit <= pwdata[14:0];
        default:                  tilt_limit <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      rcsc_pkg::REG_PULSE_MIN:  prdata = {17'b0, pulse_min};
      rcsc_pkg::REG_PULSE_MAX:  prdata = {17'b0, pulse_max};
      rcsc_pkg::REG_ARM_MARGIN: prdata = {22'b0, arm_margin};
      rcsc_pkg::REG_ROLL_LIM:   prdata = {17'b0, roll_limit};
      rcsc_pkg::REG_PITCH_LIM:  prdata = {17'b0, pitch_limit};
      rcsc_pkg::REG_YAW_LIM:    prdata = {17'b0, yaw_limit};
      rcsc_pkg::REG_THR_LIM:    prdata = {17'b0, throttle_limit};
      default:                  prdata = {17'b0, tilt_limit};
    endcase
  end

  rcsc_front u_front (
    .clk, .rst, .push, .full, .throttle_pulse, .roll_pulse, .pitch_pulse, .yaw_pulse,
    .pulse_min, .pulse_max, .arm_margin, .q_full, .q_push, .q_data(q_in)
  );

  rcsc_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_out)
  );

  rcsc_back #(
    .ROLL_DEADBAND(ROLL_DEADBAND), .PITCH_DEADBAND(PITCH_DEADBAND),
    .YAW_DEADBAND(YAW_DEADBAND), .THROTTLE_DEADBAND(THROTTLE_DEADBAND),
    .YAW_TRIM(YAW_TRIM)
  ) u_back (
    .clk, .rst, .q_empty, .q_pop, .fr(q_out), .pulse_min, .pulse_max,
    .roll_limit, .pitch_limit, .yaw_limit, .throttle_limit, .tilt_limit,
    .res_valid, .res_take(pop), .res
  );

  assign empty = !res_valid;
  assign armed = res.armed;
  assign failsafe = res.failsafe;
  assign roll_cmd = res.roll;
  assign pitch_cmd = res.pitch;
  assign yaw_cmd = res.yaw;
  assign throttle_cmd = res.thr;

endmodule

// ===== rtl/rcsc_front.sv =====
//------------------------------------------------------------------------------
// rcsc_front
// Accepts frames, tracks failsafe and arming, substitutes the center yaw pulse.
//------------------------------------------------------------------------------
module rcsc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [rcsc_pkg::PULSE_W-1:0]    throttle_pulse,
  input  logic [rcsc_pkg::PULSE_W-1:0]    roll_pulse,
  input  logic [rcsc_pkg::PULSE_W-1:0]    pitch_pulse,
  input  logic [rcsc_pkg::PULSE_W-1:0]    yaw_pulse,
  input  logic [rcsc_pkg::PULSE_W-1:0]    pulse_min,
  input  logic [rcsc_pkg::PULSE_W-1:0]    pulse_max,
  input  logic [9:0]                      arm_margin,
  input  logic                            q_full,
  output logic                            q_push,
  output rcsc_pkg::frame_t                q_data
);

  logic armed_flag, failsafe_flag;
  logic [16:0] lo_c, hi_up;
  logic signed [17:0] hi_c;
  logic fs_next, arm_go, disarm_go, armed_next;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    lo_c  = {2'b0, pulse_min} + {7'b0, arm_margin};
    hi_up = {2'b0, pulse_max} + {7'b0, arm_margin};
    hi_c  = $signed({3'b0, pulse_max}) - $signed({8'b0, arm_margin});
    fs_next = failsafe_flag || roll_pulse == '0 || pitch_pulse == '0 || yaw_pulse == '0;
    arm_go = !armed_flag && {2'b0, throttle_pulse} < lo_c && {2'b0, yaw_pulse} < lo_c &&
             {2'b0, pitch_pulse} < lo_c && $signed({3'b0, roll_pulse}) > hi_c;
    disarm_go = armed_flag && {2'b0, throttle_pulse} < lo_c &&
                {2'b0, pitch_pulse} < hi_up && $signed({3'b0, yaw_pulse}) > hi_c &&
                {2'b0, roll_pulse} < lo_c;
    armed_next = arm_go ? 1'b1 : (disarm_go ? 1'b0 : armed_flag);
    q_data.thr = throttle_pulse;
    q_data.rol = roll_pulse;
    q_data.pit = pitch_pulse;
    q_data.yaw = arm_go ? rcsc_pkg::CENTER_PULSE : yaw_pulse;
    q_data.armed = armed_next;
    q_data.failsafe = fs_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag <= 1'b0;
      failsafe_flag <= 1'b0;
    end else if (q_push) begin
      armed_flag <= armed_next;
      failsafe_flag <= fs_next;
    end
  end

  a_fs_sticky: assert property (@(posedge clk) disable iff (rst)
    failsafe_flag |=> failsafe_flag) else $error("failsafe cleared");
  a_arm_hold: assert property (@(posedge clk) disable iff (rst)
    !q_push |=> $stable(armed_flag)) else $error("armed changed without frame");
  a_center: assert property (@(posedge clk) disable iff (rst)
    (q_push && !armed_flag && q_data.armed) |-> q_data.yaw == rcsc_pkg::CENTER_PULSE)
    else $error("arming frame without center yaw");

endmodule

// ===== rtl/rcsc_queue.sv =====
//------------------------------------------------------------------------------
// rcsc_queue
// Two-entry frame queue between front and back.
//------------------------------------------------------------------------------
module rcsc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rcsc_pkg::frame_t  wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rcsc_pkg::frame_t  rdata
);

  rcsc_pkg::frame_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count overflow");

endmodule

// ===== rtl/rcsc_back.sv =====
//------------------------------------------------------------------------------
// rcsc_back
// Maps, clamps and deadbands each axis with a shared divider, limits tilt with
// a shared square root and updates the held commands only while armed.
//------------------------------------------------------------------------------
module rcsc_back #(
  parameter int ROLL_DEADBAND     = 16,
  parameter int PITCH_DEADBAND    = 16,
  parameter int YAW_DEADBAND      = 16,
  parameter int THROTTLE_DEADBAND = 16,
  parameter int YAW_TRIM          = 192
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  rcsc_pkg::frame_t             fr,
  input  logic [rcsc_pkg::PULSE_W-1:0] pulse_min,
  input  logic [rcsc_pkg::PULSE_W-1:0] pulse_max,
  input  logic [14:0]                  roll_limit,
  input  logic [14:0]                  pitch_limit,
  input  logic [14:0]                  yaw_limit,
  input  logic [14:0]                  throttle_limit,
  input  logic [14:0]                  tilt_limit,
  output logic                         res_valid,
  input  logic                         res_take,
  output rcsc_pkg::result_t            res
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_AXIS, S_SQ, S_SQRT, S_TMUL, S_TDIV, S_TNEXT, S_DONE
  } state_t;

  localparam logic [1:0] AX_ROLL  = 2'd0;
  localparam logic [1:0] AX_PITCH = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;
  localparam logic [1:0] AX_THR   = 2'd3;

  state_t state;
  logic [1:0] axis;
  logic [5:0] cnt;
  rcsc_pkg::frame_t f;
  logic signed [16:0] span;
  logic [15:0] uspan;
  logic span_neg;
  logic signed [16:0] dx;
  logic [15:0] rng;
  logic signed [34:0] prod;
  // shared restoring divider: numerator and quotient, remainder, divisor
  logic [33:0] dnum;
  logic [33:0] drem;
  logic [33:0] dden;
  logic dneg;
  logic signed [17:0] val;
  logic signed [16:0] r, p, y;
  logic [14:0] t;
  logic [31:0] sq_s, sq_r, sq_bit;
  logic sel_p;
  logic signed [31:0] tprod;
  logic signed [15:0] roll_hold, pitch_hold, yaw_hold;
  logic [14:0] thr_hold;
  logic armed_q, fs_q;

  logic [14:0] lim_cur;
  logic [rcsc_pkg::PULSE_W-1:0] x_cur;
  logic signed [18:0] mapped;
  logic signed [17:0] lim_s;
  logic [33:0] trial;
  logic signed [18:0] ax_val;
  logic [16:0] ax_mag;
  logic [15:0] db_cur;
  logic signed [17:0] ysub;
  logic signed [33:0] r_sq, p_sq;
  logic [32:0] sq_sum;
  logic [31:0] sq_try;
  logic [15:0] tq;
  logic signed [16:0] tq_s;

  always_comb begin
    unique case (axis)
      AX_ROLL: begin lim_cur = roll_limit; x_cur = f.rol; db_cur = 16'(ROLL_DEADBAND); end
      AX_PITCH: begin lim_cur = pitch_limit; x_cur = f.pit; db_cur = 16'(PITCH_DEADBAND); end
      AX_YAW: begin lim_cur = yaw_limit; x_cur = f.yaw; db_cur = 16'(YAW_DEADBAND); end
      default: begin
        lim_cur = throttle_limit; x_cur = f.thr; db_cur = 16'(THROTTLE_DEADBAND);
      end
    endcase
    lim_s = $signed({3'b0, lim_cur});
    span = $signed({2'b0, pulse_max}) - $signed({2'b0, pulse_min});
    span_neg = span < 0;
    uspan = span_neg ? 16'(-span) : 16'(span);
    trial = {drem[32:0], dnum[33]};
    prod = $signed(dx) * $signed({1'b0, rng});
    tprod = (sel_p ? 32'(p) : 32'(r)) * $signed({17'b0, tilt_limit});
    mapped = (axis == AX_THR) ? 19'(val) : 19'(val) - 19'(lim_s);
    // clamp to the axis range, then drop values inside the deadband
    ax_val = (span == 0) ? ((axis == AX_THR) ? 19'sd0 : -19'(lim_s)) : mapped;
    if (axis == AX_THR) begin
      if (ax_val < 0) ax_val = '0;
    end else if (ax_val < -19'(lim_s)) ax_val = -19'(lim_s);
    if (ax_val > 19'(lim_s)) ax_val = 19'(lim_s);
    ax_mag = 17'(ax_val < 0 ? -ax_val : ax_val);
    if (ax_mag < 17'(db_cur)) ax_val = '0;
    r_sq = 34'(r) * 34'(r);
    p_sq = 34'(p) * 34'(p);
    sq_sum = 33'($unsigned(r_sq)) + 33'($unsigned(p_sq));
    sq_try = sq_r + sq_bit;
    tq = {dnum[14:0], trial >= dden};
    tq_s = dneg ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
    ysub = 18'(y) - 18'(YAW_TRIM);
  end

  assign q_pop = (state == S_IDLE) && !q_empty && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      roll_hold <= '0; pitch_hold <= '0; yaw_hold <= '0; thr_hold <= '0;
      armed_q <= 1'b0; fs_q <= 1'b0;
      axis <= '0; cnt <= '0;
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_pop) begin
          f <= fr; axis <= AX_ROLL; state <= S_MUL;
        end
        S_MUL: begin
          dx <= $signed({2'b0, x_cur}) - $signed({2'b0, pulse_min});
          rng <= (axis == AX_THR) ? {1'b0, lim_cur} : {lim_cur, 1'b0};
          cnt <= 6'd0;
          if (span == 0) begin
            val <= '0;
            state <= S_AXIS;
            dneg <= 1'b0;
          end else begin
            state <= S_SQ; // multiply step
          end
        end
        S_SQ: begin
          // product, then load divider
          dneg <= (prod < 0) != span_neg;
          dnum <= 34'(prod < 0 ? -prod : prod) + 34'(uspan >> 1);
          dden <= {18'b0, uspan};
          drem <= '0;
          cnt <= 6'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial >= dden) begin
            drem <= trial - dden;
            dnum <= {dnum[32:0], 1'b1};
          end else begin
            drem <= trial;
            dnum <= {dnum[32:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd33) state <= S_TNEXT;
        end
        S_TNEXT: begin
          val <= dneg ? -$signed(18'(dnum[17:0])) : $signed(18'(dnum[17:0]));
          if (dnum[33:17] != '0) val <= dneg ? -18'sd65535 : 18'sd65535;
          state <= S_AXIS;
        end
        S_AXIS: begin
          unique case (axis)
            AX_ROLL:  r <= 17'(ax_val);
            AX_PITCH: p <= 17'(ax_val);
            AX_YAW:   y <= 17'(ax_val);
            default:  t <= 15'(ax_val);
          endcase
          if (axis == AX_THR) begin
            state <= S_SQRT;
            sq_bit <= 32'h4000_0000;
            sq_r <= '0;
            sel_p <= 1'b0;
            cnt <= '0;
          end else begin
            axis <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          if (cnt == 6'd0) begin
            if (sq_sum <= 33'({17'b0, tilt_limit} * {17'b0, tilt_limit})) state <= S_DONE;
            else sq_s <= 32'(sq_sum);
            cnt <= 6'd1;
          end else if (sq_bit == 0) begin
            state <= S_TMUL;
          end else begin
            if (sq_s >= sq_try) begin
              sq_s <= sq_s - sq_try;
              sq_r <= (sq_r >> 1) + sq_bit;
            end else sq_r <= sq_r >> 1;
            sq_bit <= sq_bit >> 2;
          end
        end
        S_TMUL: begin
          dneg <= tprod < 0;
          dnum <= 34'(tprod < 0 ? -tprod : tprod);
          dden <= {2'b0, sq_r};
          drem <= '0;
          cnt <= 6'd0;
          state <= S_TDIV;
        end
        S_TDIV: begin
          if (trial >= dden) begin
            drem <= trial - dden;
            dnum <= {dnum[32:0], 1'b1};
          end else begin
            drem <= trial;
            dnum <= {dnum[32:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd33) begin
            // take the last quotient bit straight from this step
            if (sel_p) begin
              p <= tq_s;
              state <= S_DONE;
            end else begin
              r <= tq_s;
              sel_p <= 1'b1;
              state <= S_TMUL;
            end
          end
        end
        S_DONE: begin
          if (f.armed) begin
            roll_hold <= 16'(r); pitch_hold <= 16'(p); thr_hold <= t;
            yaw_hold <= (ysub < -18'sd32768) ? -16'sd32768 : 16'(ysub);
          end
          armed_q <= f.armed; fs_q <= f.failsafe;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.armed = armed_q;
  assign res.failsafe = fs_q;
  assign res.roll = roll_hold;
  assign res.pitch = pitch_hold;
  assign res.yaw = yaw_hold;
  assign res.thr = thr_hold;

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> res_valid && $stable(roll_hold))
    else $error("result lost");
  a_disarm_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !f.armed) |=> $stable(roll_hold))
    else $error("hold changed while disarmed");

endmodule

// ===== dv/rc_stick_conditioner_with_arming_tb.sv =====
//------------------------------------------------------------------------------
// rc_stick_conditioner_with_arming_tb
// Self-checking bench: drives radio frames through the push/full side and
// checks every popped command set against a frame conditioner model kept in a
// scoreboard, over several register settings and idle profiles.
//------------------------------------------------------------------------------
module rc_stick_conditioner_with_arming_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DEADBAND = 16;
  localparam longint TRIM     = 192;
  localparam longint CENTER   = 1500;
  localparam int     LIMIT_CYCLES = 2000000;

  typedef struct {
    longint thr, rol, pit, yaw;
  } stick_frame_t;

  class stick_scoreboard;
    longint cfg[8];
    bit     armed_q, fs_q;
    longint roll_q, pitch_q, yaw_q, thr_q;
    rcsc_pkg::result_t pending_cmds[$];
    int     fails;

    function new();
      cfg = '{1000, 2000, 50, 480, 480, 2880, 16000, 480};
      fails = 0;
    endfunction

    function void write_reg(rcsc_pkg::reg_idx_t idx, longint val);
      cfg[idx] = (idx == rcsc_pkg::REG_ARM_MARGIN) ? (val & 'h3ff) : (val & 'h7fff);
    endfunction

    function longint div_round(longint n, longint d);
      longint un, ud, q;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q  = (un + ud / 2) / ud;
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function longint map_pulse(longint x, longint lim, bit sgn);
      longint span, lo_end, v;
      span   = cfg[rcsc_pkg::REG_PULSE_MAX] - cfg[rcsc_pkg::REG_PULSE_MIN];
      lo_end = sgn ? -lim : 0;
      if (span == 0) return lo_end;
      v = div_round((x - cfg[rcsc_pkg::REG_PULSE_MIN]) * (sgn ? 2 * lim : lim), span);
      if (sgn) v -= lim;
      if (v < lo_end) v = lo_end;
      if (v > lim) v = lim;
      return v;
    endfunction

    function longint dead(longint v);
      return ((v < 0 ? -v : v) < DEADBAND) ? 0 : v;
    endfunction

    function longint root_floor(longint s_in);
      longint unsigned s, r, b;
      s = s_in; r = 0; b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note(stick_frame_t f);
      longint lo_c, hi_c, ysrc, r, p, y, t, tl, h;
      rcsc_pkg::result_t e;
      lo_c = cfg[rcsc_pkg::REG_PULSE_MIN] + cfg[rcsc_pkg::REG_ARM_MARGIN];
      hi_c = cfg[rcsc_pkg::REG_PULSE_MAX] - cfg[rcsc_pkg::REG_ARM_MARGIN];
      ysrc = f.yaw;
      if (f.rol == 0 || f.pit == 0 || f.yaw == 0) fs_q = 1;
      if (!armed_q && f.thr < lo_c && f.yaw < lo_c && f.pit < lo_c && f.rol > hi_c) begin
        armed_q = 1;
        ysrc = CENTER;
      end else if (armed_q && f.thr < lo_c &&
                   f.pit < cfg[rcsc_pkg::REG_PULSE_MAX] + cfg[rcsc_pkg::REG_ARM_MARGIN] &&
                   f.yaw > hi_c && f.rol < lo_c) begin
        armed_q = 0;
      end
      r = dead(map_pulse(f.rol, cfg[rcsc_pkg::REG_ROLL_LIM], 1));
      p = dead(map_pulse(f.pit, cfg[rcsc_pkg::REG_PITCH_LIM], 1));
      y = dead(map_pulse(ysrc, cfg[rcsc_pkg::REG_YAW_LIM], 1));
      t = dead(map_pulse(f.thr, cfg[rcsc_pkg::REG_THR_LIM], 0));
      tl = cfg[rcsc_pkg::REG_TILT_LIM];
      if (r * r + p * p > tl * tl) begin
        h = root_floor(r * r + p * p);
        r = (r * tl) / h;
        p = (p * tl) / h;
      end
      if (armed_q) begin
        y -= TRIM;
        if (y < -32768) y = -32768;
        if (y > 32767) y = 32767;
        roll_q = r; pitch_q = p; yaw_q = y; thr_q = t;
      end
      e.armed = armed_q;
      e.failsafe = fs_q;
      e.roll = roll_q[15:0];
      e.pitch = pitch_q[15:0];
      e.yaw = yaw_q[15:0];
      e.thr = thr_q[14:0];
      pending_cmds.push_back(e);
    endfunction

    function void check(rcsc_pkg::result_t a);
      rcsc_pkg::result_t e;
      if (pending_cmds.size() == 0) begin
        $error("result beat with no frame outstanding");
        fails++;
        return;
      end
      e = pending_cmds.pop_front();
      if (a.armed !== e.armed) begin
        $error("armed exp %0d got %0d", e.armed, a.armed); fails++;
      end
      if (a.failsafe !== e.failsafe) begin
        $error("failsafe exp %0d got %0d", e.failsafe, a.failsafe); fails++;
      end
      if (a.roll !== e.roll) begin
        $error("roll_cmd exp %0d got %0d", e.roll, a.roll); fails++;
      end
      if (a.pitch !== e.pitch) begin
        $error("pitch_cmd exp %0d got %0d", e.pitch, a.pitch); fails++;
      end
      if (a.yaw !== e.yaw) begin
        $error("yaw_cmd exp %0d got %0d", e.yaw, a.yaw); fails++;
      end
      if (a.thr !== e.thr) begin
        $error("throttle_cmd exp %0d got %0d", e.thr, a.thr); fails++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               push = 0;
  logic               full;
  logic [14:0]        throttle_pulse = '0, roll_pulse = '0, pitch_pulse = '0, yaw_pulse = '0;
  logic               empty;
  logic               pop = 0;
  logic               armed, failsafe;
  logic signed [15:0] roll_cmd, pitch_cmd, yaw_cmd;
  logic [14:0]        throttle_cmd;

  stick_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int frames_sent = 0;
  int cycles = 0;

  rc_stick_conditioner_with_arming i_dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) pop <= !rst && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    rcsc_pkg::result_t a;
    cycles <= cycles + 1;
    if (!rst && pop && !empty) begin
      a.armed = armed; a.failsafe = failsafe;
      a.roll = roll_cmd; a.pitch = pitch_cmd; a.yaw = yaw_cmd; a.thr = throttle_cmd;
      sb.check(a);
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(rcsc_pkg::reg_idx_t idx, longint val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_frame(stick_frame_t f);
    bit took;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    throttle_pulse <= 15'(f.thr); roll_pulse <= 15'(f.rol);
    pitch_pulse <= 15'(f.pit); yaw_pulse <= 15'(f.yaw);
    do begin
      @(posedge clk);
      took = !full;
    end while (!took);
    sb.note(f);
    frames_sent++;
    if (frames_sent == 420) begin
      send_idle_pct = 67; recv_idle_pct = 10;
    end else if (frames_sent == 840) begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  task automatic drain_and_config(longint v[8]);
    @(negedge clk);
    push <= 0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    for (int i = 0; i < 8; i++) write_reg(rcsc_pkg::reg_idx_t'(i), v[i]);
  endtask

  function automatic longint pick(longint a, longint b);
    longint t;
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    if (a > 30000) a = 30000;
    if (b > 30000) b = 30000;
    if (a > b) begin t = a; a = b; b = t; end
    return $urandom_range(int'(b), int'(a));
  endfunction

  // Gestures and near-range frames dominate so arming and disarming keep toggling.
  function automatic stick_frame_t make_frame();
    stick_frame_t f;
    longint lo, hi, m, a, b;
    int k;
    lo = sb.cfg[rcsc_pkg::REG_PULSE_MIN];
    hi = sb.cfg[rcsc_pkg::REG_PULSE_MAX];
    m = sb.cfg[rcsc_pkg::REG_ARM_MARGIN];
    a = (lo < hi) ? lo : hi; b = (lo < hi) ? hi : lo;
    k = $urandom_range(99);
    if (k < 20) begin
      f.thr = pick(lo + m - 1, lo - 60); f.yaw = pick(lo + m - 1, lo - 60);
      f.pit = pick(lo + m - 1, lo - 60); f.rol = pick(hi - m + 1, hi + 60);
    end else if (k < 38) begin
      f.thr = pick(lo + m - 1, lo - 60); f.pit = pick(hi + m - 1, lo);
      f.yaw = pick(hi - m + 1, hi + 60); f.rol = pick(lo + m - 1, lo - 60);
    end else if (k < 85) begin
      f.thr = pick(a - 50, b + 50); f.rol = pick(a - 50, b + 50);
      f.pit = pick(a - 50, b + 50); f.yaw = pick(a - 50, b + 50);
    end else if (k < 97) begin
      f.thr = pick(0, 30000); f.rol = pick(0, 30000);
      f.pit = pick(0, 30000); f.yaw = pick(0, 30000);
    end else begin
      f.thr = pick(a, b); f.rol = pick(a, b); f.pit = pick(a, b); f.yaw = pick(a, b);
      case ($urandom_range(3))
        0: f.rol = 0;
        1: f.pit = 0;
        2: f.yaw = 0;
        default: f.thr = 0;
      endcase
    end
    return f;
  endfunction

  function automatic stick_frame_t fr(longint t, longint r, longint p, longint y);
    stick_frame_t f;
    f.thr = t; f.rol = r; f.pit = p; f.yaw = y;
    return f;
  endfunction

  initial begin
    longint sets[6][8];
    sb.armed_q = 0; sb.fs_q = 0;
    sb.roll_q = 0; sb.pitch_q = 0; sb.yaw_q = 0; sb.thr_q = 0;
    sets[0] = '{1000, 2000, 50, 480, 480, 2880, 16000, 480};
    sets[1] = '{0, 30000, 1000, 32767, 32767, 32767, 32767, 32767};
    sets[2] = '{2000, 1000, 0, 100, 100, 100, 100, 0};
    sets[3] = '{1500, 1500, 200, 1000, 1000, 1000, 1000, 500};
    sets[4] = '{30000, 0, 1000, 0, 0, 0, 0, 50};
    sets[5] = '{1000, 2000, 50, 2000, 2000, 32767, 32767, 1000};
    send_idle_pct = 10; recv_idle_pct = 67;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed frames at reset defaults
    send_frame(fr(1500, 1500, 1500, 1500));
    send_frame(fr(1000, 2000, 1000, 1000));  // arm, yaw forced to center
    send_frame(fr(1500, 1500, 1500, 1500));
    send_frame(fr(1500, 1508, 1492, 1508));  // roll and pitch inside deadband
    send_frame(fr(1500, 1509, 1491, 1510));  // roll and pitch still inside deadband, yaw outside
    send_frame(fr(2000, 2000, 2000, 2000));  // tilt scaling
    send_frame(fr(1000, 1000, 1000, 1000));
    send_frame(fr(30000, 30000, 30000, 30000));
    send_frame(fr(1, 1, 1, 1));
    send_frame(fr(16384, 16383, 21845, 10922));
    send_frame(fr(1049, 2000, 1500, 1500));
    send_frame(fr(1000, 1000, 2049, 2000));  // disarm, pitch test loose
    send_frame(fr(1500, 1500, 1500, 1500));
    send_frame(fr(1000, 2000, 1000, 1049));  // rearm
    send_frame(fr(1000, 1000, 2050, 2000));  // pitch at limit, stays armed
    send_frame(fr(0, 1500, 1500, 1500));     // throttle timeout only
    send_frame(fr(1500, 1500, 1500, 1500));
    send_frame(fr(1500, 0, 1500, 1500));     // failsafe latches
    send_frame(fr(1500, 1500, 1500, 1500));
    send_frame(fr(1000, 1000, 1000, 2000));

    for (int s = 0; s < 6; s++) begin
      drain_and_config(sets[s]);
      repeat (205) send_frame(make_frame());
    end

    @(negedge clk);
    push <= 0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rcsc_pkg.sv
rtl/rcsc_front.sv
rtl/rcsc_queue.sv
rtl/rcsc_back.sv
rtl/rc_stick_conditioner_with_arming.sv
dv/rc_stick_conditioner_with_arming_tb.sv
